// ----- hw/rtl/int_to_decimal_ascii_macros.svh -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// condition holds on every enabled clock edge
`define ITDA_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("int_to_decimal_ascii assertion failed");

// antecedent implies consequent in the same cycle
`define ITDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("int_to_decimal_ascii implication failed");

// antecedent implies consequent in the next cycle
`define ITDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("int_to_decimal_ascii next-cycle check failed");

`endif

// ----- hw/rtl/itda_pkg.sv -----
// ----------------------------------------------------------------------------
// itda_pkg
// constants, types and helper functions of the decimal text converter
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int unsigned ValueWidthDefault = 32;
  localparam int unsigned CharWidth         = 6;
  localparam int unsigned DigitWidth        = 4;
  localparam longint unsigned Radix         = 10;

  localparam logic [CharWidth-1:0] CharZero  = 6'd48;
  localparam logic [CharWidth-1:0] CharNine  = 6'd57;
  localparam logic [CharWidth-1:0] CharMinus = 6'd45;

  // number of decimal digits of the largest magnitude, 2^(width-1)
  function automatic int unsigned max_digits(int unsigned width);
    longint unsigned v;
    int unsigned     n;
    v = 64'd1 << (width - 1);
    n = 0;
    while (v != 0) begin
      v = v / Radix;
      n = n + 1;
    end
    return n;
  endfunction

  typedef struct packed {
    logic busy;
    logic done;
  } itda_conv_status_t;

endpackage

// ----- hw/rtl/itda_if.sv -----
// ----------------------------------------------------------------------------
// itda_if
// valid/ready channels of the decimal text converter
// ----------------------------------------------------------------------------
interface itda_in_if #(
  parameter int unsigned VALUE_WIDTH = itda_pkg::ValueWidthDefault
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if;
  logic                           valid;
  logic                           ready;
  logic [itda_pkg::CharWidth-1:0] text_char;
  logic                           last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ----- hw/rtl/itda_bcd_conv.sv -----
// ----------------------------------------------------------------------------
// itda_bcd_conv
// iterative shift-and-add-3 binary to decimal digit converter
// ----------------------------------------------------------------------------
module itda_bcd_conv #(
  parameter int unsigned ValueWidth = itda_pkg::ValueWidthDefault,
  parameter int unsigned NumDigits  = itda_pkg::max_digits(ValueWidth),
  parameter int unsigned IdxWidth   = $clog2(NumDigits)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ValueWidth-1:0]           mag_i,
  input  logic [IdxWidth-1:0]             rd_idx_i,
  output logic [itda_pkg::DigitWidth-1:0] digit_o,
  output itda_pkg::itda_conv_status_t     status_o
);

  localparam int unsigned CntWidth = $clog2(ValueWidth + 1);
  localparam int unsigned DW       = itda_pkg::DigitWidth;

  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [DW-1:0]         digits_q [NumDigits];
  logic [DW-1:0]         digits_d [NumDigits];
  logic [DW-1:0]         adj      [NumDigits];
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  // add-3 correction then shift one bit in
  for (genvar d = 0; d < NumDigits; d++) begin : g_digit
    assign adj[d] = (digits_q[d] >= DW'(5)) ? (digits_q[d] + DW'(3)) : digits_q[d];
    if (d == 0) begin : g_lsd
      assign digits_d[d] = start_i ? '0 : {adj[d][DW-2:0], mag_q[ValueWidth-1]};
    end else begin : g_upper
      assign digits_d[d] = start_i ? '0 : {adj[d][DW-2:0], adj[d-1][DW-1]};
    end
  end

  always_comb begin
    mag_d  = mag_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      mag_d  = mag_i;
      cnt_d  = CntWidth'(ValueWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      mag_d = {mag_q[ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (start_i || busy_q) begin
      digits_q <= digits_d;
    end
  end

  assign digit_o       = digits_q[rd_idx_i];
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ----- hw/rtl/int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// signed integer to decimal ASCII text, one character per output transaction
// ----------------------------------------------------------------------------
// Each input transaction carries one two's complement VALUE_WIDTH-bit integer.
// The block sends its decimal text most significant character first: '-' for
// a negative value, then the digits without leading zeros, with last_char set
// on the final digit (zero gives a single '0'). The most negative value is
// converted correctly. Each number passes through the shift-and-add-3
// converter, then a search for the leading digit that skips each leading
// zero digit (at most NumDigits-1, NumDigits being 10 at the default width),
// and then one character is sent per cycle while the output is not stalled.
// A new number is taken once the previous one has handed its last character
// to the output register.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = itda_pkg::ValueWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  itda_in_if.sink   in_i,
  itda_out_if.source out_o
);

  localparam int unsigned NumDigits = itda_pkg::max_digits(VALUE_WIDTH);
  localparam int unsigned IdxWidth  = $clog2(NumDigits);
  localparam int unsigned CW        = itda_pkg::CharWidth;
  localparam int unsigned DW        = itda_pkg::DigitWidth;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StConv = 5'b00010,
    StSkip = 5'b00100,
    StSign = 5'b01000,
    StEmit = 5'b10000
  } itda_state_e;

  itda_state_e                 state_q, state_d;
  logic                        neg_q, neg_d;
  logic [IdxWidth-1:0]         idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  logic [CW-1:0]               out_char_q, out_char_d;
  logic                        out_last_q, out_last_d;
  logic                        in_fire;
  logic                        slot_free;
  logic [VALUE_WIDTH-1:0]      magnitude;
  logic [DW-1:0]               digit;
  itda_pkg::itda_conv_status_t conv_status;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign magnitude  = in_i.value[VALUE_WIDTH-1] ? (~in_i.value + VALUE_WIDTH'(1))
                                                : in_i.value;

  itda_bcd_conv #(
    .ValueWidth(VALUE_WIDTH),
    .NumDigits (NumDigits),
    .IdxWidth  (IdxWidth)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .mag_i   (magnitude),
    .rd_idx_i(idx_q),
    .digit_o (digit),
    .status_o(conv_status)
  );

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          neg_d   = in_i.value[VALUE_WIDTH-1];
          idx_d   = IdxWidth'(NumDigits - 1);
          state_d = StConv;
        end
      end
      StConv: begin
        if (conv_status.done) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if ((digit == '0) && (idx_q != '0)) begin
          idx_d = idx_q - IdxWidth'(1);
        end else begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itda_pkg::CharMinus;
          out_last_d  = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = itda_pkg::CharZero + CW'(digit);
          out_last_d  = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - IdxWidth'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q      <= neg_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.text_char = out_char_q;
  assign out_o.last_char = out_last_q;

endmodule

// ----- hw/rtl/itda_checker.sv -----
// ----------------------------------------------------------------------------
// itda_checker
// port-level assertions for int_to_decimal_ascii, attached by bind
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_macros.svh"

module itda_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [itda_pkg::CharWidth-1:0] out_text_char_i,
  input logic                           out_last_char_i
);

  logic out_is_minus;
  logic out_is_digit;

  assign out_is_minus = (out_text_char_i == itda_pkg::CharMinus);
  assign out_is_digit = (out_text_char_i >= itda_pkg::CharZero) &&
                        (out_text_char_i <= itda_pkg::CharNine);

  // a pending output transaction is not withdrawn
  `ITDA_ASSERT_NXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // ready drops right after a number is taken
  `ITDA_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // a minus sign is never the last character
  `ITDA_ASSERT_IMP(a_minus_not_last, clk_i, rst_ni, out_valid_i && out_is_minus, !out_last_char_i)

  // only a minus sign or a decimal digit is sent
  `ITDA_ASSERT_IMP(a_char_range, clk_i, rst_ni, out_valid_i, out_is_minus || out_is_digit)

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_text_char_i(out_o.text_char),
  .out_last_char_i(out_o.last_char)
);
